@@ src/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the SHA-256 stream hasher
// Commands, controller states, command/status bundles, initial hash and round constants.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int LENGTH_BITS = 64;

  typedef enum logic [1:0] {
    CMD_BYTE     = 2'd0,
    CMD_BYTE_FIN = 2'd1,
    CMD_FIN      = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_80,
    ST_PAD_CHK,
    ST_LEN_LOAD,
    ST_CMP_INIT,
    ST_CMP_ROUND,
    ST_CMP_ADD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic put_en;
    logic pad_sel;
    logic len_inc;
    logic len_load;
    logic cmp_init;
    logic cmp_round;
    logic cmp_add;
    logic emit_adv;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic block_full;
    logic pos_over56;
    logic round_last;
    logic emit_last;
  } dp_stat_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

@@ src/sha_if.sv @@
// ----------------------------------------------------------------------------
// sha_if: stream channels of the SHA-256 stream hasher
// Input channel carries command and byte; output channel carries digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, cmd, data_byte, input ready);
  modport sink (input valid, cmd, data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ src/sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher: SHA-256 over a byte stream
// Top level: joins the sequencer and the datapath to the stream channels.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command per transfer: append a byte, append a byte and
//   finish, or finish alone. Bytes fill a 64-byte block big-endian.
//   out_ch gives the eight digest words of a finished message, H0 first,
//   word_index counting 0 to 7 and last_word set on the eighth.
// Sequence:
//   An append is taken while idle; the byte that fills a block starts a
//   compression (load, 64 rounds of the single round unit, add), during
//   which no further byte is taken.
//   A finish appends the 0x80 pad byte, loads the bit length and runs one
//   or two compressions, then the eight words leave at one word per cycle
//   while out_ch.ready is high. in_ready is low during a compression and,
//   after a finish, until the last digest word has been transferred.
// Reset (rst_n low, synchronous): the chaining words return to the initial
//   hash, block, byte count and bit length clear, no result is pending.
// Stall: when out_ch.ready is low, hold the current digest word and wait.
module sha256_stream_hasher (
  input logic clk,
  input logic rst_n,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  sha_pkg::dp_cmd_t  dp_cmd;
  sha_pkg::dp_stat_t dp_stat;

  // sequencer: owns the handshakes and steps the datapath
  sha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // datapath: digest word is read straight from the chaining registers
  sha_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dp_cmd),
    .stat        (dp_stat),
    .data_byte   (in_ch.data_byte),
    .digest_word (out_ch.digest_word),
    .word_index  (out_ch.word_index),
    .last_word   (out_ch.last_word)
  );

endmodule

@@ src/sha_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha_ctrl: sequencer of the SHA-256 stream hasher
// Steps byte fill, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_cmd,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sha_pkg::dp_stat_t stat,
  output sha_pkg::dp_cmd_t  cmd
);

  sha_pkg::state_t state_r, state_nxt;
  sha_pkg::state_t ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::ST_IDLE;
      ret_r   <= sha_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      sha_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (sha_pkg::cmd_t'(in_cmd))
            sha_pkg::CMD_BYTE: begin
              if (stat.block_full) begin
                state_nxt = sha_pkg::ST_CMP_INIT;
                ret_nxt   = sha_pkg::ST_IDLE;
              end
            end
            sha_pkg::CMD_BYTE_FIN: begin
              if (stat.block_full) begin
                state_nxt = sha_pkg::ST_CMP_INIT;
                ret_nxt   = sha_pkg::ST_PAD_80;
              end else begin
                state_nxt = sha_pkg::ST_PAD_80;
              end
            end
            sha_pkg::CMD_FIN: state_nxt = sha_pkg::ST_PAD_80;
            default: state_nxt = sha_pkg::ST_IDLE;
          endcase
        end
      end
      sha_pkg::ST_PAD_80: begin
        if (stat.block_full) begin
          state_nxt = sha_pkg::ST_CMP_INIT;
          ret_nxt   = sha_pkg::ST_PAD_CHK;
        end else begin
          state_nxt = sha_pkg::ST_PAD_CHK;
        end
      end
      sha_pkg::ST_PAD_CHK: begin
        if (stat.pos_over56) begin
          state_nxt = sha_pkg::ST_CMP_INIT;
          ret_nxt   = sha_pkg::ST_LEN_LOAD;
        end else begin
          state_nxt = sha_pkg::ST_LEN_LOAD;
        end
      end
      sha_pkg::ST_LEN_LOAD: begin
        state_nxt = sha_pkg::ST_CMP_INIT;
        ret_nxt   = sha_pkg::ST_EMIT;
      end
      sha_pkg::ST_CMP_INIT:  state_nxt = sha_pkg::ST_CMP_ROUND;
      sha_pkg::ST_CMP_ROUND: if (stat.round_last) state_nxt = sha_pkg::ST_CMP_ADD;
      sha_pkg::ST_CMP_ADD:   state_nxt = ret_r;
      sha_pkg::ST_EMIT: begin
        if (out_ready && stat.emit_last) state_nxt = sha_pkg::ST_IDLE;
      end
      default: state_nxt = sha_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      sha_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (sha_pkg::cmd_t'(in_cmd) == sha_pkg::CMD_BYTE ||
                         sha_pkg::cmd_t'(in_cmd) == sha_pkg::CMD_BYTE_FIN)) begin
          cmd.put_en  = 1'b1;
          cmd.len_inc = 1'b1;
        end
      end
      sha_pkg::ST_PAD_80: begin
        cmd.put_en  = 1'b1;
        cmd.pad_sel = 1'b1;
      end
      sha_pkg::ST_PAD_CHK:   cmd = '0;
      sha_pkg::ST_LEN_LOAD:  cmd.len_load = 1'b1;
      sha_pkg::ST_CMP_INIT:  cmd.cmp_init = 1'b1;
      sha_pkg::ST_CMP_ROUND: cmd.cmp_round = 1'b1;
      sha_pkg::ST_CMP_ADD:   cmd.cmp_add = 1'b1;
      sha_pkg::ST_EMIT: begin
        out_valid    = 1'b1;
        cmd.emit_adv = out_ready;
        cmd.clear    = out_ready && stat.emit_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ src/sha_dp.sv @@
// ----------------------------------------------------------------------------
// sha_dp: datapath of the SHA-256 stream hasher
// Block words, schedule ring, round logic, chaining words and bit length.
// ----------------------------------------------------------------------------
module sha_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_pkg::dp_cmd_t  cmd,
  output sha_pkg::dp_stat_t stat,
  input  logic [7:0]        data_byte,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index,
  output logic              last_word
);

  logic [31:0] blk_r [16];
  logic [31:0] blk_nxt [16];
  logic [31:0] chain_r [8];
  logic [31:0] work_r [8];
  logic [5:0]  pos_r;
  logic [5:0]  round_r;
  logic [2:0]  idx_r;
  logic [sha_pkg::LENGTH_BITS-1:0] len_r;

  logic [7:0]  put_byte;
  logic [31:0] put_word;
  logic [31:0] sched_w, w_cur, t1, t2;
  logic [63:0] len64;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  assign put_byte = cmd.pad_sel ? sha_pkg::PAD_BYTE : data_byte;
  assign put_word = {24'd0, put_byte} << {~pos_r[1:0], 3'b000};
  assign len64    = 64'(len_r);

  assign sched_w = (rotr(blk_r[14], 17) ^ rotr(blk_r[14], 19) ^ (blk_r[14] >> 10))
                 + blk_r[9]
                 + (rotr(blk_r[1], 7) ^ rotr(blk_r[1], 18) ^ (blk_r[1] >> 3))
                 + blk_r[0];
  assign w_cur = round_r[5:4] == 2'b00 ? blk_r[0] : sched_w;

  assign t1 = work_r[7]
            + (rotr(work_r[4], 6) ^ rotr(work_r[4], 11) ^ rotr(work_r[4], 25))
            + ((work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]))
            + sha_pkg::ROUND_K[round_r] + w_cur;
  assign t2 = (rotr(work_r[0], 2) ^ rotr(work_r[0], 13) ^ rotr(work_r[0], 22))
            + ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]));

  // block words: byte merge, length load, schedule shift, clear
  always_comb begin
    for (int i = 0; i < 16; i++) blk_nxt[i] = blk_r[i];
    if (cmd.put_en) begin
      for (int i = 0; i < 16; i++) begin
        if (4'(i) == pos_r[5:2]) blk_nxt[i] = blk_r[i] | put_word;
      end
    end else if (cmd.len_load) begin
      blk_nxt[14] = len64[63:32];
      blk_nxt[15] = len64[31:0];
    end else if (cmd.cmp_round) begin
      for (int i = 0; i < 15; i++) blk_nxt[i] = blk_r[i+1];
      blk_nxt[15] = w_cur;
    end else if (cmd.cmp_add || cmd.clear) begin
      for (int i = 0; i < 16; i++) blk_nxt[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) blk_r[i] <= '0;
      for (int i = 0; i < 8; i++) chain_r[i] <= sha_pkg::IV[i];
      pos_r   <= '0;
      round_r <= '0;
      idx_r   <= '0;
      len_r   <= '0;
    end else begin
      for (int i = 0; i < 16; i++) blk_r[i] <= blk_nxt[i];
      if (cmd.put_en) pos_r <= pos_r + 6'd1;
      if (cmd.len_inc) len_r <= len_r + sha_pkg::LENGTH_BITS'(8);
      if (cmd.cmp_round) round_r <= round_r + 6'd1;
      if (cmd.cmp_add) begin
        pos_r <= '0;
        for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + work_r[i];
      end
      if (cmd.emit_adv) idx_r <= idx_r + 3'd1;
      if (cmd.clear) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= sha_pkg::IV[i];
        pos_r <= '0;
        idx_r <= '0;
        len_r <= '0;
      end
    end
  end

  // working variables hold no reset: always loaded before the first round
  always_ff @(posedge clk) begin
    if (cmd.cmp_init) begin
      for (int i = 0; i < 8; i++) work_r[i] <= chain_r[i];
    end else if (cmd.cmp_round) begin
      work_r[7] <= work_r[6];
      work_r[6] <= work_r[5];
      work_r[5] <= work_r[4];
      work_r[4] <= work_r[3] + t1;
      work_r[3] <= work_r[2];
      work_r[2] <= work_r[1];
      work_r[1] <= work_r[0];
      work_r[0] <= t1 + t2;
    end
  end

  assign stat.block_full = pos_r == 6'd63;
  assign stat.pos_over56 = pos_r > 6'd56;
  assign stat.round_last = round_r == 6'd63;
  assign stat.emit_last  = idx_r == 3'd7;

  assign digest_word = chain_r[idx_r];
  assign word_index  = idx_r;
  assign last_word   = idx_r == 3'd7;

endmodule

@@ src/sha_checker.sv @@
// ----------------------------------------------------------------------------
// sha_checker: port-level assertions for the SHA-256 stream hasher
// Checks output stall hold and ordering, input blocking and silent appends seen at the top-level ports.
// ----------------------------------------------------------------------------
module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
                                && $stable(out_word_index))
    else $error("digest word changed while stalled");

  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input open while digest is pending");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word does not match word_index");

  a_end_of_digest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_word |=> !out_valid && in_ready)
    else $error("output continued after last word");

  a_append_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == sha_pkg::CMD_BYTE |=> !out_valid)
    else $error("append produced a result");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_cmd          (in_ch.cmd),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_digest_word (out_ch.digest_word),
  .out_word_index  (out_ch.word_index),
  .out_last_word   (out_ch.last_word)
);
